@@ design/assert_macros.svh @@
// Assertion macros shared by the frame builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property at every rising clock edge outside reset.
`define SFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition in one cycle is followed by another in the next.
`define SFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/sfb_pkg.sv @@
// Types, constants and CRC function of the sync frame builder.
`timescale 1ns / 1ps
package sfb_pkg;

    localparam logic [15:0] SYNC_WORD_RST = 16'hEB90;
    localparam logic [15:0] CRC_SEED_RST  = 16'hFFFF;
    localparam logic [7:0]  HDR_FILL_BYTE = 8'hFF;

    // Register indexes of the configuration port
    localparam logic [7:0] CFG_SYNC_WORD = 8'd0;
    localparam logic [7:0] CFG_CRC_SEED  = 8'd1;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  index;
        logic [15:0] value;
    } t_cfg_word;

    // One classified item as it waits between front and back
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic        last_byte;
        logic        open;
        logic [15:0] sync_word;
        logic [15:0] crc_seed;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_SYNC_HI,
        ST_SYNC_LO,
        ST_FILL0,
        ST_FILL1,
        ST_FILL2,
        ST_FILL3,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CRC_LO,
        ST_CRC_HI
    } t_step;

    localparam logic [15:0] NIBBLE_TAB [16] = '{
        16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
        16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
    };

    // Reflected CRC-16 update over one byte, low nibble first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = NIBBLE_TAB[b[3:0] ^ crc[3:0]] ^ {4'h0, crc[15:4]};
        c = NIBBLE_TAB[b[7:4] ^ c[3:0]] ^ {4'h0, c[15:4]};
        return c;
    endfunction

endpackage

@@ design/sfb_stream_if.sv @@
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
interface sfb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/sfb_front.sv @@
// Front end: config registers, frame tracking and item classification.
`timescale 1ns / 1ps
module sfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfb_stream_if.sink    i_in,
    sfb_stream_if.sink    i_cfg,
    sfb_stream_if.source  o_q
);
    logic        r_in_frame;
    logic        n_in_frame;
    logic [15:0] r_sync_word;
    logic [15:0] n_sync_word;
    logic [15:0] r_crc_seed;
    logic [15:0] n_crc_seed;
    logic        w_accept;
    sfb_pkg::t_in_word w_in;
    sfb_pkg::t_cfg_word w_cfg;

    assign w_in     = i_in.data;
    assign w_cfg    = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = o_q.ready;
    assign o_q.valid   = i_in.valid;
    assign w_accept    = i_in.valid && o_q.ready;

    always_comb begin
        o_q.data.payload_byte = w_in.payload_byte;
        o_q.data.frame_type   = w_in.frame_type;
        o_q.data.frame_length = w_in.frame_length;
        o_q.data.last_byte    = w_in.last_byte;
        o_q.data.open         = !r_in_frame;
        o_q.data.sync_word    = r_sync_word;
        o_q.data.crc_seed     = r_crc_seed;
    end

    always_comb begin
        n_in_frame = r_in_frame;
        if (w_accept) begin
            n_in_frame = !w_in.last_byte;
        end
    end

    always_comb begin
        n_sync_word = r_sync_word;
        n_crc_seed  = r_crc_seed;
        if (i_cfg.valid) begin
            case (w_cfg.index)
                sfb_pkg::CFG_SYNC_WORD: n_sync_word = w_cfg.value;
                sfb_pkg::CFG_CRC_SEED:  n_crc_seed  = w_cfg.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_sync_word <= sfb_pkg::SYNC_WORD_RST;
            r_crc_seed  <= sfb_pkg::CRC_SEED_RST;
        end else begin
            r_in_frame  <= n_in_frame;
            r_sync_word <= n_sync_word;
            r_crc_seed  <= n_crc_seed;
        end
    end
endmodule

@@ design/sfb_queue.sv @@
// Small flip-flop FIFO between front and back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfb_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfb_stream_if.sink    i_wr,
    sfb_stream_if.source  o_rd
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfb_pkg::t_cmd      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               w_push;
    logic               w_pop;

    assign i_wr.ready = (r_count != CNT_W'(DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr.valid && i_wr.ready;
    assign w_pop      = o_rd.valid && o_rd.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `SFB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue overfilled")
    `SFB_ASSERT(a_pop_nonempty, i_clk, i_rst_n, o_rd.ready |-> o_rd.valid, "pop from empty queue")
endmodule

@@ design/sfb_back.sv @@
// Back end: byte sequencer, CRC accumulation and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfb_stream_if.sink    i_q,
    sfb_stream_if.source  o_out
);
    sfb_pkg::t_step     r_step;
    sfb_pkg::t_step     n_step;
    sfb_pkg::t_step     w_cur;
    logic               r_busy;
    logic               n_busy;
    logic [15:0]        r_crc;
    logic [15:0]        n_crc;
    logic               r_out_valid;
    logic               n_out_valid;
    sfb_pkg::t_out_word r_out;
    sfb_pkg::t_out_word n_out;
    sfb_pkg::t_cmd      w_head;
    logic               w_fire;
    logic               w_end;
    logic [7:0]         w_byte;
    logic               w_crc_step;

    assign w_head = i_q.data;
    assign w_cur  = r_busy ? r_step
                  : (w_head.open ? sfb_pkg::ST_SYNC_HI : sfb_pkg::ST_DATA);
    assign w_end  = (w_cur == sfb_pkg::ST_CRC_HI)
                  || (w_cur == sfb_pkg::ST_DATA && !w_head.last_byte);
    assign w_fire = i_q.valid && (!r_out_valid || o_out.ready);

    assign i_q.ready   = w_fire && w_end;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Next step
    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (w_fire) begin
            n_busy = !w_end;
            case (w_cur)
                sfb_pkg::ST_SYNC_HI: n_step = sfb_pkg::ST_SYNC_LO;
                sfb_pkg::ST_SYNC_LO: n_step = sfb_pkg::ST_FILL0;
                sfb_pkg::ST_FILL0:   n_step = sfb_pkg::ST_FILL1;
                sfb_pkg::ST_FILL1:   n_step = sfb_pkg::ST_FILL2;
                sfb_pkg::ST_FILL2:   n_step = sfb_pkg::ST_FILL3;
                sfb_pkg::ST_FILL3:   n_step = sfb_pkg::ST_TYPE;
                sfb_pkg::ST_TYPE:    n_step = sfb_pkg::ST_LEN;
                sfb_pkg::ST_LEN:     n_step = sfb_pkg::ST_DATA;
                sfb_pkg::ST_DATA:    n_step = sfb_pkg::ST_CRC_LO;
                sfb_pkg::ST_CRC_LO:  n_step = sfb_pkg::ST_CRC_HI;
                default:             n_step = sfb_pkg::ST_DATA;
            endcase
        end
    end

    // Byte selection, CRC and output word
    always_comb begin
        w_crc_step = 1'b0;
        case (w_cur)
            sfb_pkg::ST_SYNC_HI: w_byte = w_head.sync_word[15:8];
            sfb_pkg::ST_SYNC_LO: w_byte = w_head.sync_word[7:0];
            sfb_pkg::ST_FILL0,
            sfb_pkg::ST_FILL1,
            sfb_pkg::ST_FILL2,
            sfb_pkg::ST_FILL3:   w_byte = sfb_pkg::HDR_FILL_BYTE;
            sfb_pkg::ST_TYPE:    w_byte = w_head.frame_type;
            sfb_pkg::ST_LEN:     w_byte = w_head.frame_length;
            sfb_pkg::ST_DATA:    w_byte = w_head.payload_byte;
            sfb_pkg::ST_CRC_LO: begin
                w_byte     = r_crc[7:0];
                w_crc_step = 1'b1;
            end
            sfb_pkg::ST_CRC_HI: begin
                w_byte     = r_crc[15:8];
                w_crc_step = 1'b1;
            end
            default:             w_byte = w_head.payload_byte;
        endcase

        n_crc       = r_crc;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid     = 1'b1;
            n_out.out_byte  = w_byte;
            n_out.run_last  = w_end;
            n_out.frame_end = (w_cur == sfb_pkg::ST_CRC_HI);
            if (!w_crc_step) begin
                n_crc = sfb_pkg::crc_byte(
                    (w_cur == sfb_pkg::ST_SYNC_HI) ? w_head.crc_seed : r_crc, w_byte);
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= sfb_pkg::ST_DATA;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    `SFB_ASSERT(a_busy_has_head, i_clk, i_rst_n, r_busy |-> i_q.valid, "busy without queued item")
    `SFB_ASSERT_NEXT(a_mid_item_busy, i_clk, i_rst_n, w_fire && !w_end, r_busy, "lost item progress")
    `SFB_ASSERT(a_end_is_last, i_clk, i_rst_n, (r_out_valid && r_out.frame_end) |-> r_out.run_last, "frame end not last")
endmodule

@@ design/sync_frame_builder_crc16.sv @@
// Top level of the sync frame builder with CRC-16 trailer.
`timescale 1ns / 1ps
// Usage:
//   i_in  : payload words (payload_byte, frame_type, frame_length, last_byte).
//           The first word after reset or after a last_byte word opens a frame.
//   o_out : wire bytes (out_byte, run_last, frame_end). run_last marks the last
//           byte caused by an input word; frame_end marks the CRC high byte.
//   i_cfg : register writes (index 0 sync word, index 1 CRC seed), always
//           ready; write only while the block is idle.
// Path: the first byte of a word is written into the queue, then taken by the
//   back end into the output register, where it is valid on o_out.
// Throughput: one output byte per cycle while o_out is ready, set by the back
//   end sequencer. A middle word yields 1 byte, an opening word 9, a closing
//   word 3, a single-word frame 11. The front accepts while the queue has room.
// Reset: sync word returns to EB90, seed to FFFF, no frame open, queue and
//   output register empty.
// Stall: when o_out.ready is low the output register holds its byte, the back
//   end stops, and the queue fills; i_in.ready drops once the queue is full.
module sync_frame_builder_crc16 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfb_stream_if.sink    i_in,
    sfb_stream_if.source  o_out,
    sfb_stream_if.sink    i_cfg
);
    // Classified words from front to queue, and from queue to back
    sfb_stream_if #(.T(sfb_pkg::t_cmd)) w_q_wr ();
    sfb_stream_if #(.T(sfb_pkg::t_cmd)) w_q_rd ();

    // Front: track frame boundaries and snapshot the config into each word
    sfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_q     (w_q_wr.source)
    );

    // Queue: decouple acceptance from byte sequencing
    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr.sink),
        .o_rd    (w_q_rd.source)
    );

    // Back: emit header, payload and CRC bytes one per cycle while o_out is ready
    sfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q_rd.sink),
        .o_out   (o_out)
    );
endmodule
